// File: rtl/array_binary_tree_engine_assert.svh
// ---------------------------------------------------------------------------
// array_binary_tree_engine assertion macros
// concurrent checks on clk of the using module; ABT_ASSERT reset by rst_n
// ---------------------------------------------------------------------------
`ifndef ARRAY_BINARY_TREE_ENGINE_ASSERT_SVH
`define ARRAY_BINARY_TREE_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS
`define ABT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ABT_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ABT_ASSERT(lbl, prop, msg)
`define ABT_ASSERT_NR(lbl, prop, msg)
`endif

`endif

// File: rtl/abt_pkg.sv
// ---------------------------------------------------------------------------
// abt_pkg
// shared constants, opcodes and control structs of the tree engine
// ---------------------------------------------------------------------------
package abt_pkg;

  localparam int TREE_SLOTS = 64;

  localparam logic [3:0] OP_CLEAR  = 4'd0;
  localparam logic [3:0] OP_LOAD   = 4'd1;
  localparam logic [3:0] OP_ROOT   = 4'd2;
  localparam logic [3:0] OP_DEPTH  = 4'd3;
  localparam logic [3:0] OP_VALUE  = 4'd4;
  localparam logic [3:0] OP_ASSIGN = 4'd5;
  localparam logic [3:0] OP_PARENT = 4'd6;
  localparam logic [3:0] OP_LCHILD = 4'd7;
  localparam logic [3:0] OP_RCHILD = 4'd8;
  localparam logic [3:0] OP_LSIB   = 4'd9;
  localparam logic [3:0] OP_RSIB   = 4'd10;
  localparam logic [3:0] OP_DELETE = 4'd11;

  typedef struct packed {
    logic [3:0] opcode;
    logic [2:0] node_level;
    logic [5:0] node_order;
    logic [5:0] load_index;
    logic [7:0] new_value;
    logic [7:0] search_value;
    logic       side;
  } req_t;

  typedef struct packed {
    logic take;
    logic exec;
    logic scan_step;
    logic fetch_issue;
    logic cnt_clr;
    logic del_step;
    logic depth_step;
  } cmd_t;

  typedef struct packed {
    logic go_scan;
    logic go_del;
    logic hit;
    logic scan_last;
    logic cnt_last;
  } sts_t;

  // bit length of a slot count up to 64
  function automatic logic [2:0] bit_len(input logic [6:0] n);
    logic [2:0] d;
    d = 3'd0;
    for (int b = 0; b < 7; b++) begin
      if (n[b]) d = 3'(b + 1);
    end
    return d;
  endfunction

endpackage

// File: rtl/abt_if.sv
// ---------------------------------------------------------------------------
// abt_in_if / abt_out_if
// valid/ready channels carrying request and result beats
// ---------------------------------------------------------------------------
interface abt_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] opcode;
  logic [2:0] node_level;
  logic [5:0] node_order;
  logic [5:0] load_index;
  logic [7:0] new_value;
  logic [7:0] search_value;
  logic       side;

  modport source (output valid, opcode, node_level, node_order, load_index,
                  new_value, search_value, side, input ready);
  modport sink (input valid, opcode, node_level, node_order, load_index,
                new_value, search_value, side, output ready);
endinterface

interface abt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] result_value;
  logic [2:0] tree_depth;
  logic       is_empty;
  logic       status;

  modport source (output valid, result_value, tree_depth, is_empty, status,
                  input ready);
  modport sink (input valid, result_value, tree_depth, is_empty, status,
                output ready);
endinterface

// File: rtl/abt_dpath.sv
// ---------------------------------------------------------------------------
// abt_dpath
// node store, occupancy bits, sweep counter and result registers
// ---------------------------------------------------------------------------
module abt_dpath (
  input  logic          clk,
  input  logic          rst_n,
  input  abt_pkg::req_t req,
  input  abt_pkg::cmd_t cmd,
  output abt_pkg::sts_t sts,
  output logic [7:0]    res_value,
  output logic [2:0]    res_depth,
  output logic          res_empty,
  output logic          res_status
);
  import abt_pkg::*;

  logic [7:0]            mem [0:TREE_SLOTS-1];
  req_t                  req_r;
  logic [7:0]            rdata_r;
  logic [7:0]            rd_idx_r;
  logic                  pend_r;
  logic                  scan_vld_r;
  logic [TREE_SLOTS-1:0] nz_r;
  logic [TREE_SLOTS-1:0] hit_r;
  logic [6:0]            cnt_r;
  logic [6:0]            last_r;
  logic [7:0]            res_r;
  logic                  st_r;

  logic [TREE_SLOTS-1:0] nz_nxt;
  logic [TREE_SLOTS-1:0] hit_nxt;
  logic [6:0]            cnt_nxt;

  logic [6:0] pos_w;
  logic       pos_ok;
  logic [7:0] pos_idx, par_idx, ch_l, ch_r, del_root;
  logic       asg_bad, del_ok, st_calc;
  logic [7:0] gated;
  logic [5:0] si;
  logic       cand;
  logic [7:0] tgt;
  logic       is_rel, exec_rd, scan_issue, ren, wen;
  logic [7:0] raddr;
  logic [5:0] waddr, k;
  logic [7:0] kl, kr;

  function automatic logic nz_at(input logic [7:0] x, input logic [TREE_SLOTS-1:0] v);
    return (x[7:6] == 2'b00) && v[x[5:0]];
  endfunction

  // position decode
  always_comb begin
    pos_w    = 7'd1 << (req_r.node_level - 3'd1);
    pos_ok   = (req_r.node_level != 3'd0) && (req_r.node_order != 6'd0) &&
               ({1'b0, req_r.node_order} <= pos_w);
    pos_idx  = {1'b0, pos_w} - 8'd2 + {2'b00, req_r.node_order};
    par_idx  = (pos_idx - 8'd1) >> 1;
    ch_l     = {pos_idx[6:0], 1'b1};
    ch_r     = ch_l + 8'd1;
    del_root = ch_l + {7'd0, req_r.side};
    del_ok   = pos_ok && nz_at(pos_idx, nz_r);
    if (pos_idx[7:6] != 2'b00)        asg_bad = 1'b1;
    else if (pos_idx == 8'd0)         asg_bad = !nz_r[0];
    else if (req_r.new_value != 8'd0) asg_bad = !nz_at(par_idx, nz_r);
    else                              asg_bad = nz_at(ch_l, nz_r) || nz_at(ch_r, nz_r);
    is_rel = (req_r.opcode >= OP_PARENT) && (req_r.opcode <= OP_RSIB);
    unique case (req_r.opcode)
      OP_CLEAR, OP_LOAD, OP_DEPTH: st_calc = 1'b0;
      OP_ROOT:   st_calc = !nz_r[0];
      OP_VALUE:  st_calc = !pos_ok;
      OP_ASSIGN: st_calc = !pos_ok || asg_bad;
      OP_PARENT, OP_LCHILD, OP_RCHILD, OP_LSIB, OP_RSIB: st_calc = 1'b0;
      OP_DELETE: st_calc = !del_ok;
      default:   st_calc = 1'b1;
    endcase
  end

  // scan compare against the slot read last cycle
  always_comb begin
    gated = nz_at(rd_idx_r, nz_r) ? rdata_r : 8'd0;
    si    = rd_idx_r[5:0];
    unique case (req_r.opcode)
      OP_PARENT: begin cand = (si != 6'd0);            tgt = {2'b00, si - 6'd1} >> 1; end
      OP_LCHILD: begin cand = 1'b1;                    tgt = {1'b0, si, 1'b1}; end
      OP_RCHILD: begin cand = 1'b1;                    tgt = {1'b0, si, 1'b1} + 8'd1; end
      OP_LSIB:   begin cand = (si != 6'd0) && !si[0];  tgt = {2'b00, si - 6'd1}; end
      default:   begin cand = si[0];                   tgt = {2'b00, si} + 8'd1; end
    endcase
  end

  always_comb begin
    sts.go_scan   = is_rel && nz_r[0];
    sts.go_del    = (req_r.opcode == OP_DELETE) && del_ok && (del_root[7:6] == 2'b00);
    sts.hit       = scan_vld_r && cand && (gated == req_r.search_value);
    sts.scan_last = scan_vld_r && (rd_idx_r == 8'd63);
    sts.cnt_last  = (cnt_r[5:0] == 6'd63);
  end

  // memory port selection
  always_comb begin
    exec_rd    = cmd.exec && ((req_r.opcode == OP_ROOT) ||
                              ((req_r.opcode == OP_VALUE) && pos_ok));
    scan_issue = cmd.scan_step && !cnt_r[6] && !cmd.fetch_issue;
    ren        = exec_rd || cmd.fetch_issue || scan_issue;
    if (cmd.fetch_issue)                 raddr = tgt;
    else if (scan_issue)                 raddr = {1'b0, cnt_r};
    else if (req_r.opcode == OP_VALUE)   raddr = pos_idx;
    else                                 raddr = 8'd0;
    wen   = cmd.exec && ((req_r.opcode == OP_LOAD) ||
                         ((req_r.opcode == OP_ASSIGN) && !st_calc));
    waddr = (req_r.opcode == OP_LOAD) ? req_r.load_index : pos_idx[5:0];
    k     = cnt_r[5:0];
    kl    = {1'b0, k, 1'b1};
    kr    = kl + 8'd1;
  end

  // occupancy, sweep marks and counter next values
  always_comb begin
    nz_nxt  = nz_r;
    hit_nxt = hit_r;
    cnt_nxt = cnt_r;
    if (cmd.exec && (req_r.opcode == OP_CLEAR)) nz_nxt = '0;
    else if (wen) nz_nxt[waddr] = (req_r.new_value != 8'd0);
    if (cmd.exec) begin
      hit_nxt = '0;
      if (sts.go_del) begin
        hit_nxt[del_root[5:0]] = 1'b1;
        cnt_nxt = del_root[6:0];
      end else begin
        cnt_nxt = 7'd0;
      end
    end
    // subtree sweep: mark occupied children, drop the node
    if (cmd.del_step) begin
      if (hit_r[k]) begin
        if (nz_at(kl, nz_r)) hit_nxt[kl[5:0]] = 1'b1;
        if (nz_at(kr, nz_r)) hit_nxt[kr[5:0]] = 1'b1;
        nz_nxt[k] = 1'b0;
      end
      cnt_nxt = cnt_r + 7'd1;
    end
    if (cmd.depth_step || scan_issue) cnt_nxt = cnt_r + 7'd1;
    if (cmd.cnt_clr) cnt_nxt = 7'd0;
  end

  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= req_r.new_value;
    if (ren) begin
      rdata_r  <= mem[raddr[5:0]];
      rd_idx_r <= raddr;
    end
    if (cmd.take) req_r <= req;
    if (cmd.exec) begin
      st_r   <= st_calc;
      last_r <= 7'd0;
    end else if (cmd.depth_step && nz_r[k]) begin
      last_r <= {1'b0, k} + 7'd1;
    end
    if (cmd.exec)    res_r <= 8'd0;
    else if (pend_r) res_r <= gated;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nz_r       <= '0;
      hit_r      <= '0;
      cnt_r      <= 7'd0;
      pend_r     <= 1'b0;
      scan_vld_r <= 1'b0;
    end else begin
      pend_r     <= exec_rd || cmd.fetch_issue;
      scan_vld_r <= scan_issue;
      nz_r       <= nz_nxt;
      hit_r      <= hit_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  assign res_value  = res_r;
  assign res_depth  = bit_len(last_r);
  assign res_empty  = !nz_r[0];
  assign res_status = st_r;

endmodule

// File: rtl/abt_ctrl.sv
// ---------------------------------------------------------------------------
// abt_ctrl
// request sequencer: execute, scan or delete sweep, depth sweep, respond
// ---------------------------------------------------------------------------
`include "array_binary_tree_engine_assert.svh"

module abt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output abt_pkg::cmd_t cmd,
  input  abt_pkg::sts_t sts
);
  import abt_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_EXEC   = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_DELETE = 6'b001000,
    ST_DEPTH  = 6'b010000,
    ST_RESP   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.go_scan)     state_nxt = ST_SCAN;
        else if (sts.go_del) state_nxt = ST_DELETE;
        else                 state_nxt = ST_DEPTH;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.hit) begin
          cmd.fetch_issue = 1'b1;
          cmd.cnt_clr     = 1'b1;
          state_nxt       = ST_DEPTH;
        end else if (sts.scan_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = ST_DEPTH;
        end
      end
      ST_DELETE: begin
        cmd.del_step = 1'b1;
        if (sts.cnt_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = ST_DEPTH;
        end
      end
      ST_DEPTH: begin
        cmd.depth_step = 1'b1;
        if (sts.cnt_last) state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_RESP);

  `ABT_ASSERT(a_one_item, !(in_ready && out_valid), "request taken while result pending")
  `ABT_ASSERT(a_take_exec, (in_valid && in_ready) |=> (state_r == ST_EXEC), "accept not executed")
  `ABT_ASSERT(a_depth_resp, (state_r == ST_DEPTH) && sts.cnt_last |=> out_valid, "no result after depth sweep")

endmodule

// File: rtl/array_binary_tree_engine.sv
// ---------------------------------------------------------------------------
// array_binary_tree_engine
// Level-order binary tree of bytes (0 = empty) in a 64-slot store. One
// request at a time: each takes an execute step, then a full depth sweep
// over all 64 occupancy bits before the result beat. Key searches first
// scan the slots through the single store read port, stopping at a hit;
// subtree delete first sweeps from the selected child slot (left or right
// by side) to the end of the store. The result beat is held in registers
// until taken; a new request is taken only after that.
// ---------------------------------------------------------------------------
module array_binary_tree_engine (
  input logic      clk,
  input logic      rst_n,
  abt_in_if.sink   in_chan,
  abt_out_if.source out_chan
);
  import abt_pkg::*;

  req_t req;
  cmd_t cmd;
  sts_t sts;

  always_comb begin
    req.opcode       = in_chan.opcode;
    req.node_level   = in_chan.node_level;
    req.node_order   = in_chan.node_order;
    req.load_index   = in_chan.load_index;
    req.new_value    = in_chan.new_value;
    req.search_value = in_chan.search_value;
    req.side         = in_chan.side;
  end

  abt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  abt_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .cmd        (cmd),
    .sts        (sts),
    .res_value  (out_chan.result_value),
    .res_depth  (out_chan.tree_depth),
    .res_empty  (out_chan.is_empty),
    .res_status (out_chan.status)
  );

endmodule
